// ----- sv/ordered_process_queue_assert.svh -----
// Assertion macros used by the ordered process queue sequencer.
`ifndef ORDERED_PROCESS_QUEUE_ASSERT_SVH
`define ORDERED_PROCESS_QUEUE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define OPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define OPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/opq_pkg.sv -----
// Package of types, codes and widths for the ordered process queue.
`default_nettype none

package opq_pkg;

  localparam int TIME_W     = 32;
  localparam int NAME_KEY_W = 64;
  localparam int TAG_IN_W   = 16;
  localparam int POS_W      = 4;
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int CNT_OUT_W  = 5;
  // One-hot prefix step vector, wide enough for the largest capacity.
  localparam int STEP_MAX   = 8;

  localparam int CAPACITY_DEF   = 16;
  localparam int NAME_BYTES_DEF = 8;
  localparam int TAG_BITS_DEF   = 16;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_POP    = 3'd2,
    FN_REMOVE = 3'd3,
    FN_READ   = 3'd4
  } opq_func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } opq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_PFX,
    S_APPLY
  } opq_state_e;

  // The to_tail bit makes the compare mark only the tail, as append needs.
  typedef struct packed {
    logic                cmp;
    logic                to_tail;
    logic                pfx;
    logic                ins;
    logic                del;
    logic [STEP_MAX-1:0] step_oh;
  } opq_cell_ctrl_t;

  typedef struct packed {
    logic load;
    logic emit;
  } opq_out_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/opq_cell.sv -----
// One storage cell of the queue chain: an entry, its compare and its insert flag.
`default_nettype none

module opq_cell #(
  parameter int IDX     = 0,
  parameter int CNT_W   = 5,
  parameter int ENTRY_W = 144,
  parameter int KEY_W   = 128,
  parameter int LOG     = 4
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire opq_pkg::opq_cell_ctrl_t ctrl_i,
  input  wire  [CNT_W-1:0]            count_i,
  input  wire  [opq_pkg::POS_W-1:0]   pos_i,
  input  wire  [ENTRY_W-1:0]          new_i,
  input  wire  [ENTRY_W-1:0]          prev_i,
  input  wire  [ENTRY_W-1:0]          next_i,
  input  wire  [LOG-1:0]              pfx_i,
  output logic [ENTRY_W-1:0]          ent_o,
  output logic                        flag_o
);

  localparam logic [CNT_W-1:0] IdxCnt = CNT_W'(IDX);

  logic [ENTRY_W-1:0] ent_q, ent_d;
  logic               flag_q, flag_d;
  logic               occupied;
  logic               at_tail;
  logic               precedes;

  assign occupied = IdxCnt < count_i;
  assign at_tail  = IdxCnt == count_i;
  // Service, arrival and name sit side by side, so one compare is lexicographic.
  assign precedes = ent_q[ENTRY_W-1 -: KEY_W] < new_i[ENTRY_W-1 -: KEY_W];

  always_comb begin
    flag_d = flag_q;
    if (ctrl_i.cmp) begin
      flag_d = (occupied & ~precedes & ~ctrl_i.to_tail) | at_tail;
    end else if (ctrl_i.pfx) begin
      flag_d = flag_q | (|(ctrl_i.step_oh[LOG-1:0] & pfx_i));
    end
  end

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.ins) begin
      if (pfx_i[0]) begin
        ent_d = prev_i;
      end else if (flag_q) begin
        ent_d = new_i;
      end
    end else if (ctrl_i.del) begin
      if (IdxCnt >= pos_i) begin
        ent_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o  = ent_q;
  assign flag_o = flag_q;

endmodule

`default_nettype wire

// ----- sv/opq_ctrl.sv -----
// Sequencer of the queue: handshakes, entry count, status and cell commands.
`default_nettype none

module opq_ctrl #(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = 5,
  parameter int LOG      = 4
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  [opq_pkg::FUNC_W-1:0]        func_i,
  input  wire  [opq_pkg::POS_W-1:0]         position_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [opq_pkg::STATUS_W-1:0]      status_o,
  output logic [opq_pkg::CNT_OUT_W-1:0]     entry_count_o,
  output logic [CNT_W-1:0]                  count_o,
  output logic [opq_pkg::POS_W-1:0]         sel_pos_o,
  output opq_pkg::opq_cell_ctrl_t           cell_ctrl_o,
  output opq_pkg::opq_out_ctrl_t            out_ctrl_o
);

  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  opq_pkg::opq_state_e               state_q, state_d;
  logic [opq_pkg::FUNC_W-1:0]        func_q;
  logic [opq_pkg::POS_W-1:0]         pos_q;
  logic [CNT_W-1:0]                  count_q, count_d, count_nx;
  logic [opq_pkg::STEP_MAX-1:0]      step_q, step_d;
  logic                              out_valid_q, out_valid_d;
  opq_pkg::opq_status_e              status_q, status_d, stat;
  logic [opq_pkg::CNT_OUT_W-1:0]     cnt_out_q, cnt_out_d;
  logic                              in_accept;
  logic                              full;
  logic                              empty;
  logic                              add_in;
  logic                              out_free;
  logic                              apply_go;
  logic                              ins_ok;
  logic                              del_ok;
  logic                              emit;
  logic [opq_pkg::POS_W-1:0]         sel_pos;

  assign in_accept = in_valid_i & (state_q == opq_pkg::S_IDLE);
  assign full      = count_q == CapCnt;
  assign empty     = count_q == '0;
  assign add_in    = (func_i == opq_pkg::FN_APPEND) || (func_i == opq_pkg::FN_INSERT);
  assign out_free  = ~out_valid_q | ~out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      opq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (add_in && !full) ? opq_pkg::S_CMP : opq_pkg::S_APPLY;
        end
      end
      opq_pkg::S_CMP: begin
        state_d = opq_pkg::S_PFX;
      end
      opq_pkg::S_PFX: begin
        if (step_q[LOG-1]) begin
          state_d = opq_pkg::S_APPLY;
        end
      end
      opq_pkg::S_APPLY: begin
        if (out_free) begin
          state_d = opq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = opq_pkg::S_IDLE;
      end
    endcase
  end

  // Operation decode, evaluated against the stored count.
  always_comb begin
    stat     = opq_pkg::STAT_OK;
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    emit     = 1'b0;
    sel_pos  = pos_q;
    count_nx = count_q;
    case (opq_pkg::opq_func_e'(func_q))
      opq_pkg::FN_APPEND, opq_pkg::FN_INSERT: begin
        if (full) begin
          stat = opq_pkg::STAT_FULL;
        end else begin
          ins_ok   = 1'b1;
          count_nx = CNT_W'(count_q + 1'b1);
        end
      end
      opq_pkg::FN_POP: begin
        sel_pos = '0;
        if (empty) begin
          stat = opq_pkg::STAT_EMPTY;
        end else begin
          emit     = 1'b1;
          del_ok   = 1'b1;
          count_nx = CNT_W'(count_q - 1'b1);
        end
      end
      opq_pkg::FN_REMOVE, opq_pkg::FN_READ: begin
        if (empty) begin
          stat = opq_pkg::STAT_EMPTY;
        end else if (pos_q >= count_q) begin
          stat = opq_pkg::STAT_RANGE;
        end else begin
          emit = 1'b1;
          if (func_q == opq_pkg::FN_REMOVE) begin
            del_ok   = 1'b1;
            count_nx = CNT_W'(count_q - 1'b1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Outputs toward the cells and the result register. An append marks only
  // the tail cell in the compare cycle, so the new entry lands at the end.
  always_comb begin
    apply_go            = (state_q == opq_pkg::S_APPLY) & out_free;
    cell_ctrl_o.cmp     = state_q == opq_pkg::S_CMP;
    cell_ctrl_o.to_tail = func_q == opq_pkg::FN_APPEND;
    cell_ctrl_o.pfx     = state_q == opq_pkg::S_PFX;
    cell_ctrl_o.ins     = apply_go & ins_ok;
    cell_ctrl_o.del     = apply_go & del_ok;
    cell_ctrl_o.step_oh = step_q;
    out_ctrl_o.load     = apply_go;
    out_ctrl_o.emit     = emit;
  end

  always_comb begin
    count_d     = apply_go ? count_nx : count_q;
    step_d      = step_q;
    if (state_q == opq_pkg::S_CMP) begin
      step_d = opq_pkg::STEP_MAX'(1);
    end else if (state_q == opq_pkg::S_PFX) begin
      step_d = step_q << 1;
    end
    out_valid_d = apply_go | (out_valid_q & out_stall_i);
    status_d    = apply_go ? stat : status_q;
    cnt_out_d   = apply_go ? opq_pkg::CNT_OUT_W'(count_nx) : cnt_out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= opq_pkg::S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= func_i;
      pos_q  <= position_i;
    end
    status_q  <= status_d;
    cnt_out_q <= cnt_out_d;
  end

  assign in_stall_o    = state_q != opq_pkg::S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = cnt_out_q;
  assign count_o       = count_q;
  assign sel_pos_o     = sel_pos;

`include "ordered_process_queue_assert.svh"

  `OPQ_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CapCnt, "entry count exceeds capacity")
  `OPQ_ASSERT_NEXT(a_accept_busy, in_accept, state_q != opq_pkg::S_IDLE, "accept left block idle")
  `OPQ_ASSERT_NEXT(a_count_hold, !apply_go, $stable(count_q), "count moved outside apply")
  `OPQ_ASSERT_NEXT(a_ins_grow, cell_ctrl_o.ins, count_q == $past(count_q) + 1'b1, "no growth")
  `OPQ_ASSERT_IMPL(a_ins_del_excl, 1'b1, !(cell_ctrl_o.ins && cell_ctrl_o.del), "insert and delete together")

endmodule

`default_nettype wire

// ----- sv/ordered_process_queue.sv -----
// Top level of the ordered process queue: cell chain, sequencer and result register.
//
// The queue holds up to CAPACITY process entries, compacted from the head.
// Input channel: in_valid_i / in_stall_o; a beat carries func_i and the new
// entry fields (service, arrival, name, tag) plus position_i. A beat is taken
// on a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i; every input beat yields exactly
// one result beat with status, the selected entry and the count afterwards.
// Append and ordered insert run through these steps in order: accept the
// beat, let all cells compare against the new entry in parallel, run the
// doubling prefix that marks the insert point, and shift the chain.
// Pop, remove, read, refused inserts and unused codes go from accept
// straight to the final apply step.
// The result register decouples the sides: a new beat is accepted while a
// result still waits, and only the final shift cycle waits while the
// receiver stalls. Reset empties the queue at once; entry storage is not
// cleared because slots at or past the count are never read.
`default_nettype none

module ordered_process_queue #(
  parameter int CAPACITY   = opq_pkg::CAPACITY_DEF,
  parameter int NAME_BYTES = opq_pkg::NAME_BYTES_DEF,
  parameter int TAG_BITS   = opq_pkg::TAG_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [opq_pkg::FUNC_W-1:0]       func_i,
  input  wire  [opq_pkg::TIME_W-1:0]       service_time_i,
  input  wire  [opq_pkg::TIME_W-1:0]       arrival_time_i,
  input  wire  [opq_pkg::NAME_KEY_W-1:0]   name_key_i,
  input  wire  [opq_pkg::TAG_IN_W-1:0]     proc_tag_i,
  input  wire  [opq_pkg::POS_W-1:0]        position_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [opq_pkg::STATUS_W-1:0]     status_o,
  output logic [opq_pkg::TIME_W-1:0]       out_service_time_o,
  output logic [opq_pkg::TIME_W-1:0]       out_arrival_time_o,
  output logic [opq_pkg::NAME_KEY_W-1:0]   out_name_key_o,
  output logic [opq_pkg::TAG_IN_W-1:0]     out_proc_tag_o,
  output logic [opq_pkg::CNT_OUT_W-1:0]    entry_count_o
);

  // Only the top NAME_BYTES name bytes and the low tag bits that fit the
  // input port are kept in the cells.
  localparam int NAME_W    = 8 * NAME_BYTES;
  localparam int TAG_W     = (TAG_BITS < opq_pkg::TAG_IN_W) ? TAG_BITS : opq_pkg::TAG_IN_W;
  localparam int KEY_W     = 2 * opq_pkg::TIME_W + NAME_W;
  localparam int ENTRY_W   = KEY_W + TAG_W;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int LOG       = $clog2(CAPACITY);
  localparam int RD_N      = (CAPACITY < (1 << opq_pkg::POS_W)) ? CAPACITY
                                                                 : (1 << opq_pkg::POS_W);
  localparam int NameShift = opq_pkg::NAME_KEY_W - NAME_W;

  opq_pkg::opq_cell_ctrl_t       cell_ctrl;
  opq_pkg::opq_out_ctrl_t        out_ctrl;
  logic [CNT_W-1:0]              count;
  logic [opq_pkg::POS_W-1:0]     sel_pos;
  logic                          in_accept;
  logic [ENTRY_W-1:0]            new_q;
  logic [ENTRY_W-1:0]            ent [CAPACITY];
  logic [CAPACITY-1:0]           flag;
  logic [ENTRY_W-1:0]            sel_ent;
  logic [opq_pkg::NAME_KEY_W-1:0] sel_name_ext;
  logic [opq_pkg::TIME_W-1:0]    out_svc_q;
  logic [opq_pkg::TIME_W-1:0]    out_arr_q;
  logic [opq_pkg::NAME_KEY_W-1:0] out_name_q;
  logic [opq_pkg::TAG_IN_W-1:0]  out_tag_q;

  opq_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .LOG      (LOG)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .count_o       (count),
    .sel_pos_o     (sel_pos),
    .cell_ctrl_o   (cell_ctrl),
    .out_ctrl_o    (out_ctrl)
  );

  assign in_accept = in_valid_i & ~in_stall_o;

  // The new entry is held for the compare, prefix and shift cycles.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      new_q <= {service_time_i, arrival_time_i,
                name_key_i[opq_pkg::NAME_KEY_W-1 -: NAME_W], proc_tag_i[TAG_W-1:0]};
    end
  end

  // The chain: each cell sees its neighbors' entries for shifting and the
  // flags at distances 1, 2, 4, ... toward the head for the prefix steps.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ENTRY_W-1:0] prev_ent;
    logic [ENTRY_W-1:0] next_ent;
    logic [LOG-1:0]     taps;

    if (k == 0) begin : g_head
      assign prev_ent = '0;
    end else begin : g_body
      assign prev_ent = ent[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_mid
      assign next_ent = ent[k+1];
    end

    for (genvar s = 0; s < LOG; s++) begin : g_tap
      if (k >= (1 << s)) begin : g_link
        assign taps[s] = flag[k - (1 << s)];
      end else begin : g_none
        assign taps[s] = 1'b0;
      end
    end

    opq_cell #(
      .IDX     (k),
      .CNT_W   (CNT_W),
      .ENTRY_W (ENTRY_W),
      .KEY_W   (KEY_W),
      .LOG     (LOG)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .count_i (count),
      .pos_i   (sel_pos),
      .new_i   (new_q),
      .prev_i  (prev_ent),
      .next_i  (next_ent),
      .pfx_i   (taps),
      .ent_o   (ent[k]),
      .flag_o  (flag[k])
    );
  end

  // Only the first sixteen cells are reachable by a position, so the read
  // select is a small one-hot AND-OR over them.
  always_comb begin
    sel_ent = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (sel_pos == opq_pkg::POS_W'(k)) begin
        sel_ent = sel_ent | ent[k];
      end
    end
  end

  assign sel_name_ext = opq_pkg::NAME_KEY_W'(sel_ent[TAG_W +: NAME_W]);

  // Result register; fields are zero when no entry is returned.
  always_ff @(posedge clk_i) begin
    if (out_ctrl.load) begin
      if (out_ctrl.emit) begin
        out_svc_q  <= sel_ent[ENTRY_W-1 -: opq_pkg::TIME_W];
        out_arr_q  <= sel_ent[ENTRY_W-1-opq_pkg::TIME_W -: opq_pkg::TIME_W];
        out_name_q <= sel_name_ext << NameShift;
        out_tag_q  <= opq_pkg::TAG_IN_W'(sel_ent[TAG_W-1:0]);
      end else begin
        out_svc_q  <= '0;
        out_arr_q  <= '0;
        out_name_q <= '0;
        out_tag_q  <= '0;
      end
    end
  end

  assign out_service_time_o = out_svc_q;
  assign out_arrival_time_o = out_arr_q;
  assign out_name_key_o     = out_name_q;
  assign out_proc_tag_o     = out_tag_q;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the ordered process queue with random handshake gaps.
module testbench;
  import opq_pkg::*;

  localparam int QUEUE_DEPTH   = CAPACITY_DEF;
  localparam int RANDOM_OPS    = 680;
  localparam int DRAIN_CYCLES  = 24;
  localparam int CYCLE_LIMIT   = 200000;

  // Only the top NAME_BYTES bytes of the name and the low TAG_BITS of the tag are kept.
  localparam logic [NAME_KEY_W-1:0] NAME_KEEP =
    {NAME_KEY_W{1'b1}} << (8 * (8 - NAME_BYTES_DEF));
  localparam logic [TAG_IN_W-1:0] TAG_KEEP = TAG_IN_W'((64'd1 << TAG_BITS_DEF) - 1);

  // Function codes above the last operation do nothing but report ok.
  localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = FUNC_W'(FN_READ) + 1'b1;
  localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = '1;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

  typedef struct {
    logic [FUNC_W-1:0]     func;
    logic [TIME_W-1:0]     svc;
    logic [TIME_W-1:0]     arr;
    logic [NAME_KEY_W-1:0] name;
    logic [TAG_IN_W-1:0]   tag;
    logic [POS_W-1:0]      pos;
    int unsigned           gap;
  } queue_op_t;

  typedef struct packed {
    logic [TIME_W-1:0]     svc;
    logic [TIME_W-1:0]     arr;
    logic [NAME_KEY_W-1:0] name;
    logic [TAG_IN_W-1:0]   tag;
  } proc_entry_t;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    proc_entry_t          entry;
    logic [CNT_OUT_W-1:0] count;
  } op_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Input channel, driven from registers that start at known values.
  logic                  in_valid = 1'b0;
  logic                  in_stall_o;
  logic [FUNC_W-1:0]     drv_func = '0;
  logic [TIME_W-1:0]     drv_svc  = '0;
  logic [TIME_W-1:0]     drv_arr  = '0;
  logic [NAME_KEY_W-1:0] drv_name = '0;
  logic [TAG_IN_W-1:0]   drv_tag  = '0;
  logic [POS_W-1:0]      drv_pos  = '0;

  // Output channel.
  logic                  out_valid_o;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [TIME_W-1:0]     out_service_time_o;
  logic [TIME_W-1:0]     out_arrival_time_o;
  logic [NAME_KEY_W-1:0] out_name_key_o;
  logic [TAG_IN_W-1:0]   out_proc_tag_o;
  logic [CNT_OUT_W-1:0]  entry_count_o;

  queue_op_t   pending_ops[$];
  op_result_t  expected_results[$];
  proc_entry_t model_slots[$];

  int unsigned idle_cycles  = 0;
  int unsigned stall_left   = 0;
  int unsigned beats_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;
  int unsigned mismatches   = 0;
  int unsigned n_full       = 0;
  int unsigned n_empty      = 0;
  int unsigned n_range      = 0;
  int unsigned n_sorted     = 0;
  int unsigned n_taken_out  = 0;
  bit          gap_burst    = 1'b0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  ordered_process_queue dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .func_i             (drv_func),
    .service_time_i     (drv_svc),
    .arrival_time_i     (drv_arr),
    .name_key_i         (drv_name),
    .proc_tag_i         (drv_tag),
    .position_i         (drv_pos),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .status_o           (status_o),
    .out_service_time_o (out_service_time_o),
    .out_arrival_time_o (out_arrival_time_o),
    .out_name_key_o     (out_name_key_o),
    .out_proc_tag_o     (out_proc_tag_o),
    .entry_count_o      (entry_count_o)
  );

  // Entry a goes ahead of entry b when (service, arrival, name) is smaller.
  function automatic bit entry_precedes(proc_entry_t a, proc_entry_t b);
    if (a.svc != b.svc) return a.svc < b.svc;
    if (a.arr != b.arr) return a.arr < b.arr;
    return a.name < b.name;
  endfunction

  // Applies one operation to the shadow queue and returns the result it must produce.
  function automatic op_result_t apply_queue_op(queue_op_t op);
    op_result_t  res;
    proc_entry_t fresh;
    int          idx;
    res.status = STAT_OK;
    res.entry  = '0;
    fresh = '{svc: op.svc, arr: op.arr, name: op.name & NAME_KEEP, tag: op.tag & TAG_KEEP};
    case (op.func)
      FN_APPEND, FN_INSERT: begin
        if (model_slots.size() >= QUEUE_DEPTH) begin
          res.status = STAT_FULL;
          n_full++;
        end else if (op.func == FN_APPEND) begin
          model_slots.push_back(fresh);
        end else begin
          // The new entry lands ahead of the first entry that does not strictly precede it.
          idx = 0;
          while (idx < model_slots.size() && entry_precedes(model_slots[idx], fresh)) idx++;
          model_slots.insert(idx, fresh);
          n_sorted++;
        end
      end
      FN_POP, FN_REMOVE, FN_READ: begin
        idx = (op.func == FN_POP) ? 0 : int'(op.pos);
        if (model_slots.size() == 0) begin
          res.status = STAT_EMPTY;
          n_empty++;
        end else if (idx >= model_slots.size()) begin
          res.status = STAT_RANGE;
          n_range++;
        end else begin
          res.entry = model_slots[idx];
          if (op.func != FN_READ) model_slots.delete(idx);
          n_taken_out++;
        end
      end
      default: ;
    endcase
    res.count = CNT_OUT_W'(model_slots.size());
    return res;
  endfunction

  // Queues one operation and its predicted result; both follow the same issue order.
  task automatic issue_op(input logic [FUNC_W-1:0] f, input logic [TIME_W-1:0] s,
                          input logic [TIME_W-1:0] a, input logic [NAME_KEY_W-1:0] n,
                          input logic [TAG_IN_W-1:0] t, input logic [POS_W-1:0] p);
    queue_op_t op;
    op.func = f;
    op.svc  = s;
    op.arr  = a;
    op.name = n;
    op.tag  = t;
    op.pos  = p;
    op.gap  = gap_burst ? 0 : $urandom_range(0, 7);
    pending_ops.push_back(op);
    expected_results.push_back(apply_queue_op(op));
  endtask

  // Sort keys are drawn mostly from a narrow range so that ties are frequent.
  function automatic logic [TIME_W-1:0] rand_time();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return TIME_W'($urandom_range(0, 3));
      5:             return '0;
      6:             return '1;
      default:       return $urandom;
    endcase
  endfunction

  function automatic logic [NAME_KEY_W-1:0] rand_name();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return {8'($urandom_range(97, 99)), 56'd0};
      4:       return {8'($urandom_range(97, 98)), 8'($urandom_range(97, 98)), 48'd0};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Positions mostly fall inside the current count, sometimes anywhere.
  function automatic logic [POS_W-1:0] rand_pos();
    if (model_slots.size() != 0 && $urandom_range(0, 4) != 0)
      return POS_W'($urandom_range(0, model_slots.size() - 1));
    return POS_W'($urandom_range(0, 15));
  endfunction

  // Driver: presents the next operation once its idle gap has passed and holds it while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      idle_cycles <= 0;
      beats_taken <= 0;
    end else begin
      if (in_valid && !in_stall_o) beats_taken <= beats_taken + 1;
      if (!in_valid || !in_stall_o) begin
        if (pending_ops.size() != 0 && idle_cycles >= pending_ops[0].gap) begin
          drv_func    <= pending_ops[0].func;
          drv_svc     <= pending_ops[0].svc;
          drv_arr     <= pending_ops[0].arr;
          drv_name    <= pending_ops[0].name;
          drv_tag     <= pending_ops[0].tag;
          drv_pos     <= pending_ops[0].pos;
          in_valid    <= 1'b1;
          idle_cycles <= 0;
          void'(pending_ops.pop_front());
        end else begin
          in_valid <= 1'b0;
          if (pending_ops.size() != 0) idle_cycles <= idle_cycles + 1;
        end
      end
    end
  end

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: result %0d %s mismatch, expected %0h, actual %0h",
               $time, results_seen, what, want, got);
      mismatches++;
    end
  endtask

  // Monitor: takes result beats, checks them in order and draws a stall after each one.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    int unsigned hold;
    if (!rst_ni) begin
      out_stall    <= 1'b0;
      stall_left   <= 0;
      results_seen <= 0;
    end else if (out_valid_o && !out_stall) begin
      if (results_seen >= beats_taken) begin
        $display("%0t: result beat with no operation outstanding, expected none, actual status %0h",
                 $time, status_o);
        mismatches++;
      end else begin
        check_field("status", expected_results[results_seen].status, status_o);
        check_field("service time", expected_results[results_seen].entry.svc,
                    out_service_time_o);
        check_field("arrival time", expected_results[results_seen].entry.arr,
                    out_arrival_time_o);
        check_field("name key", expected_results[results_seen].entry.name, out_name_key_o);
        check_field("process tag", expected_results[results_seen].entry.tag, out_proc_tag_o);
        check_field("entry count", expected_results[results_seen].count, entry_count_o);
      end
      results_seen <= results_seen + 1;
      // Every third stretch of results runs without back-pressure.
      hold = ((results_seen / 60) % 3 == 0) ? 0 : $urandom_range(0, 7);
      stall_left <= hold;
      out_stall  <= (hold != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  initial begin : stimulus
    phase_e      phase;
    int unsigned roll;
    int unsigned span;
    int unsigned random_issued;
    logic [FUNC_W-1:0] f;

    // Operations on an empty queue, then the unused codes.
    issue_op(FN_POP, $urandom, $urandom, {$urandom, $urandom}, 16'($urandom), '0);
    issue_op(FN_READ, $urandom, $urandom, {$urandom, $urandom}, 16'($urandom), '0);
    issue_op(FN_REMOVE, $urandom, $urandom, {$urandom, $urandom}, 16'($urandom), '1);
    for (int c = FN_SPARE_FIRST; c <= FN_SPARE_LAST; c++)
      issue_op(FUNC_W'(c), $urandom, $urandom, {$urandom, $urandom}, 16'($urandom), rand_pos());
    // Extreme keys, an exact tie, and ordering decided by arrival and by name.
    issue_op(FN_APPEND, '1, '1, '1, '1, '0);
    issue_op(FN_INSERT, '0, '0, '0, '0, '0);
    issue_op(FN_INSERT, '1, '1, '1, 16'h1234, '0);
    issue_op(FN_INSERT, 32'd5, 32'd7, {8'h62, 56'd0}, 16'h0b0b, '0);
    issue_op(FN_INSERT, 32'd5, 32'd7, {8'h61, 56'd0}, 16'h0a0a, '0);
    issue_op(FN_INSERT, 32'd5, 32'd6, {8'h7a, 56'd0}, 16'h0c0c, '0);
    // Reads at the first and last slots and past the count, then removals and a pop.
    issue_op(FN_READ, $urandom, $urandom, '0, '0, 4'd0);
    issue_op(FN_READ, $urandom, $urandom, '0, '0, 4'd5);
    issue_op(FN_READ, $urandom, $urandom, '0, '0, 4'd6);
    issue_op(FN_READ, $urandom, $urandom, '0, '0, '1);
    issue_op(FN_REMOVE, $urandom, $urandom, '0, '0, 4'd2);
    issue_op(FN_REMOVE, $urandom, $urandom, '0, '0, 4'd4);
    issue_op(FN_REMOVE, $urandom, $urandom, '0, '0, 4'd4);
    issue_op(FN_POP, $urandom, $urandom, '0, '0, '0);
    issue_op(FN_SPARE_LAST, $urandom, $urandom, '0, '0, '0);
    issue_op(FN_APPEND, 32'd3, 32'd1, {8'h61, 56'd0}, '0, '0);

    // Random phases push the queue toward full or empty, or keep it in the middle.
    random_issued = 0;
    while (random_issued < RANDOM_OPS) begin
      phase     = phase_e'($urandom_range(0, 2));
      span      = $urandom_range(8, 40);
      gap_burst = ($urandom_range(0, 3) == 0);
      repeat (span) begin
        roll = $urandom_range(0, 99);
        if (roll >= 96) begin
          f = FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
        end else begin
          case (phase)
            PH_FILL:  f = (roll < 50) ? FN_INSERT : (roll < 78) ? FN_APPEND :
                          (roll < 86) ? FN_READ : (roll < 91) ? FN_POP : FN_REMOVE;
            PH_DRAIN: f = (roll < 30) ? FN_POP : (roll < 60) ? FN_REMOVE :
                          (roll < 82) ? FN_READ : (roll < 90) ? FN_INSERT : FN_APPEND;
            default:  f = (roll < 25) ? FN_INSERT : (roll < 40) ? FN_APPEND :
                          (roll < 60) ? FN_READ : (roll < 78) ? FN_POP : FN_REMOVE;
          endcase
        end
        issue_op(f, rand_time(), rand_time(), rand_name(), 16'($urandom), rand_pos());
        random_issued++;
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || in_valid) @(posedge clk_i);
    while (results_seen < beats_taken) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d operations: %0d ordered inserts, %0d entries returned, %0d checked.",
             expected_results.size(), n_sorted, n_taken_out, results_seen);
    $display("Error paths hit: %0d full refusals, %0d empty queue, %0d bad position.",
             n_full, n_empty, n_range);
    if (mismatches == 0 && results_seen == expected_results.size()) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: ends a run that reaches the cycle limit and reports it as a mismatch.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: run stopped after %0d cycles with %0d of %0d results seen",
             $time, cycle_count, results_seen, expected_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
